>>> src/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Types, constants and the microcode table of the LCD nibble expander writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WAIT_W     = 7;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned RW_POS_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned STEP_W     = 5;

  localparam logic [RW_POS_W-1:0] BACKLIGHT_POS = 4'd7;
  localparam logic [BYTE_W-1:0]   BACKLIGHT_ON  = 8'h01;

  localparam logic [WAIT_W-1:0] WAIT_US_NONE  = 7'd0;
  localparam logic [WAIT_W-1:0] WAIT_US_SHORT = 7'd1;
  localparam logic [WAIT_W-1:0] WAIT_US_LONG  = 7'd100;

  // reset values of the configuration registers
  localparam logic [POS_W-1:0]    SELECT_POS_RST = 3'd1;
  localparam logic [RW_POS_W-1:0] RW_POS_RST     = 4'd2;
  localparam logic [POS_W-1:0]    STROBE_POS_RST = 3'd3;
  localparam logic [POS_W-1:0]    NIBBLE_POS_RST = 3'd4;

  typedef enum logic [1:0] {
    OP_COMMAND   = 2'd0,
    OP_DATA      = 2'd1,
    OP_BACKLIGHT = 2'd2,
    OP_NIBBLE    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELECT_POS = 2'd0,
    CFG_RW_POS     = 2'd1,
    CFG_STROBE_POS = 2'd2,
    CFG_NIBBLE_POS = 2'd3
  } cfg_idx_e;

  // pin addressed by one microcode step
  typedef enum logic [2:0] {
    PIN_SELECT,
    PIN_RW,
    PIN_DATA,
    PIN_STROBE,
    PIN_BACKLIGHT
  } pin_e;

  // level written to that pin
  typedef enum logic [2:0] {
    LVL_ZERO,
    LVL_ONE,
    LVL_IS_DATA,
    LVL_DATA_BIT,
    LVL_BACKLIGHT
  } lvl_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_SHORT,
    WAIT_LONG
  } wait_e;

  typedef enum logic [0:0] {
    JMP_NONE,
    JMP_NO_RW
  } jmp_e;

  typedef struct packed {
    pin_e              pin;
    lvl_e              lvl;
    logic [1:0]        line;     // data line within the nibble
    logic              hi_half;  // take the upper nibble of the value
    wait_e             wait_sel;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    op_e              op;
    logic [BYTE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expander_byte;
    logic [WAIT_W-1:0] wait_after_us;
    logic              last;
  } out_t;

  // sequencer to datapath
  typedef struct packed {
    logic  fire;
    ctrl_t ctrl;
  } step_t;

  // datapath to sequencer
  typedef struct packed {
    logic slot_free;
    logic rw_absent;
  } dp_status_t;

  // program entry points
  localparam logic [STEP_W-1:0] ENTRY_BYTE      = 5'd0;
  localparam logic [STEP_W-1:0] ENTRY_LOW_NIB   = 5'd9;
  localparam logic [STEP_W-1:0] ENTRY_BACKLIGHT = 5'd16;

  function automatic ctrl_t data_step(logic hi, logic [1:0] line);
    ctrl_t c;
    c = '{pin: PIN_DATA, lvl: LVL_DATA_BIT, line: line, hi_half: hi,
          wait_sel: WAIT_NONE, jmp: JMP_NONE, target: '0, last: 1'b0};
    return c;
  endfunction

  function automatic ctrl_t strobe_step(lvl_e lvl, wait_e w, logic last);
    ctrl_t c;
    c = '{pin: PIN_STROBE, lvl: lvl, line: 2'd0, hi_half: 1'b0,
          wait_sel: w, jmp: JMP_NONE, target: '0, last: last};
    return c;
  endfunction

  // control store: one frame per step
  function automatic ctrl_t ucode(logic [STEP_W-1:0] addr);
    ctrl_t c;
    c = '{pin: PIN_BACKLIGHT, lvl: LVL_BACKLIGHT, line: 2'd0, hi_half: 1'b0,
          wait_sel: WAIT_NONE, jmp: JMP_NONE, target: '0, last: 1'b1};
    case (addr)
      5'd0: c = '{pin: PIN_SELECT, lvl: LVL_IS_DATA, line: 2'd0, hi_half: 1'b0,
                  wait_sel: WAIT_NONE, jmp: JMP_NO_RW, target: 5'd2, last: 1'b0};
      5'd1: c = '{pin: PIN_RW, lvl: LVL_ZERO, line: 2'd0, hi_half: 1'b0,
                  wait_sel: WAIT_NONE, jmp: JMP_NONE, target: '0, last: 1'b0};
      5'd2:  c = data_step(1'b1, 2'd0);
      5'd3:  c = data_step(1'b1, 2'd1);
      5'd4:  c = data_step(1'b1, 2'd2);
      5'd5:  c = data_step(1'b1, 2'd3);
      5'd6:  c = strobe_step(LVL_ZERO, WAIT_SHORT, 1'b0);
      5'd7:  c = strobe_step(LVL_ONE, WAIT_SHORT, 1'b0);
      5'd8:  c = strobe_step(LVL_ZERO, WAIT_LONG, 1'b0);
      5'd9:  c = data_step(1'b0, 2'd0);
      5'd10: c = data_step(1'b0, 2'd1);
      5'd11: c = data_step(1'b0, 2'd2);
      5'd12: c = data_step(1'b0, 2'd3);
      5'd13: c = strobe_step(LVL_ZERO, WAIT_SHORT, 1'b0);
      5'd14: c = strobe_step(LVL_ONE, WAIT_SHORT, 1'b0);
      5'd15: c = strobe_step(LVL_ZERO, WAIT_LONG, 1'b1);
      default: ;  // backlight step and unused addresses
    endcase
    return c;
  endfunction

endpackage

>>> src/clnw_seq.sv
// ----------------------------------------------------------------------------
// clnw_seq
// Step counter and control store; holds the item being sent.
// ----------------------------------------------------------------------------
module clnw_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clnw_pkg::in_t       in_data_i,
  input  clnw_pkg::dp_status_t status_i,
  output clnw_pkg::in_t       item_o,
  output clnw_pkg::step_t     step_o
);

  logic                        busy_q, busy_d;
  logic [clnw_pkg::STEP_W-1:0] pc_q, pc_d;
  clnw_pkg::in_t               item_q, item_d;
  clnw_pkg::ctrl_t             ctrl;
  logic                        accept;
  logic                        fire;

  assign ctrl       = clnw_pkg::ucode(pc_q);
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign fire       = busy_q && status_i.slot_free;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    item_d = item_q;
    if (accept) begin
      busy_d = 1'b1;
      item_d = in_data_i;
      case (in_data_i.op)
        clnw_pkg::OP_BACKLIGHT: pc_d = clnw_pkg::ENTRY_BACKLIGHT;
        clnw_pkg::OP_NIBBLE:    pc_d = clnw_pkg::ENTRY_LOW_NIB;
        default:                pc_d = clnw_pkg::ENTRY_BYTE;
      endcase
    end else if (fire) begin
      if (ctrl.last) begin
        busy_d = 1'b0;
      end else if (ctrl.jmp == clnw_pkg::JMP_NO_RW && status_i.rw_absent) begin
        pc_d = ctrl.target;
      end else begin
        pc_d = pc_q + {{(clnw_pkg::STEP_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;
  assign step_o = '{fire: fire, ctrl: ctrl};

endmodule

>>> src/clnw_dp.sv
// ----------------------------------------------------------------------------
// clnw_dp
// Pin positions, shadow byte and output frame register.
// ----------------------------------------------------------------------------
module clnw_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [clnw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [clnw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  clnw_pkg::in_t                    item_i,
  input  clnw_pkg::step_t                  step_i,
  output clnw_pkg::dp_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output clnw_pkg::out_t                   out_data_o
);

  logic [clnw_pkg::POS_W-1:0]    sel_pos_q, sel_pos_d;
  logic [clnw_pkg::RW_POS_W-1:0] rw_pos_q, rw_pos_d;
  logic [clnw_pkg::POS_W-1:0]    stb_pos_q, stb_pos_d;
  logic [clnw_pkg::POS_W-1:0]    nib_pos_q, nib_pos_d;
  logic [clnw_pkg::BYTE_W-1:0]   shadow_q, shadow_d;
  logic                          out_valid_q, out_valid_d;
  clnw_pkg::out_t                out_q, out_d;

  logic [clnw_pkg::RW_POS_W-1:0] pin_pos;
  logic                          level;
  logic [3:0]                    nibble;
  logic [clnw_pkg::WAIT_W-1:0]   wait_us;

  // configuration registers
  always_comb begin
    sel_pos_d = sel_pos_q;
    rw_pos_d  = rw_pos_q;
    stb_pos_d = stb_pos_q;
    nib_pos_d = nib_pos_q;
    if (cfg_valid_i) begin
      case (clnw_pkg::cfg_idx_e'(cfg_index_i))
        clnw_pkg::CFG_SELECT_POS: sel_pos_d = cfg_data_i[clnw_pkg::POS_W-1:0];
        clnw_pkg::CFG_RW_POS:     rw_pos_d  = cfg_data_i;
        clnw_pkg::CFG_STROBE_POS: stb_pos_d = cfg_data_i[clnw_pkg::POS_W-1:0];
        clnw_pkg::CFG_NIBBLE_POS: nib_pos_d = cfg_data_i[clnw_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign nibble = step_i.ctrl.hi_half ? item_i.value[7:4] : item_i.value[3:0];

  always_comb begin
    case (step_i.ctrl.pin)
      clnw_pkg::PIN_SELECT: pin_pos = {1'b0, sel_pos_q};
      clnw_pkg::PIN_RW:     pin_pos = rw_pos_q;
      clnw_pkg::PIN_DATA:   pin_pos = {1'b0, nib_pos_q} + {2'b00, step_i.ctrl.line};
      clnw_pkg::PIN_STROBE: pin_pos = {1'b0, stb_pos_q};
      default:              pin_pos = clnw_pkg::BACKLIGHT_POS;
    endcase
  end

  always_comb begin
    case (step_i.ctrl.lvl)
      clnw_pkg::LVL_ONE:      level = 1'b1;
      clnw_pkg::LVL_IS_DATA:  level = (item_i.op == clnw_pkg::OP_DATA);
      clnw_pkg::LVL_DATA_BIT: level = nibble[step_i.ctrl.line];
      clnw_pkg::LVL_BACKLIGHT: level = (item_i.value == clnw_pkg::BACKLIGHT_ON);
      default:                level = 1'b0;
    endcase
  end

  always_comb begin
    case (step_i.ctrl.wait_sel)
      clnw_pkg::WAIT_SHORT: wait_us = clnw_pkg::WAIT_US_SHORT;
      clnw_pkg::WAIT_LONG:  wait_us = clnw_pkg::WAIT_US_LONG;
      default:              wait_us = clnw_pkg::WAIT_US_NONE;
    endcase
  end

  always_comb begin
    shadow_d    = shadow_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (step_i.fire) begin
      // positions past bit 7 leave the shadow alone but still send a frame
      if (!pin_pos[clnw_pkg::RW_POS_W-1]) begin
        shadow_d[pin_pos[clnw_pkg::POS_W-1:0]] = level;
      end
      out_d       = '{expander_byte: shadow_d, wait_after_us: wait_us,
                      last: step_i.ctrl.last};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_pos_q   <= clnw_pkg::SELECT_POS_RST;
      rw_pos_q    <= clnw_pkg::RW_POS_RST;
      stb_pos_q   <= clnw_pkg::STROBE_POS_RST;
      nib_pos_q   <= clnw_pkg::NIBBLE_POS_RST;
      shadow_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sel_pos_q   <= sel_pos_d;
      rw_pos_q    <= rw_pos_d;
      stb_pos_q   <= stb_pos_d;
      nib_pos_q   <= nib_pos_d;
      shadow_q    <= shadow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o    = '{slot_free: !out_valid_q || !out_stall_i,
                         rw_absent: rw_pos_q[clnw_pkg::RW_POS_W-1]};
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/char_lcd_nibble_expander_writer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_expander_writer_top
// Character LCD writer in 4-bit mode through an 8-bit serial pin expander.
// ----------------------------------------------------------------------------
// Each accepted item is played out by a small microcode program, one expander
// frame per step and at most one frame per clock: a command or data byte gives
// 16 frames (15 when the read/write position is 8 or more), a bare nibble 7
// and a backlight change 1. The item is registered when it is accepted, and
// the next item is accepted in the cycle after its last frame has gone into
// the output register; a stall on the output side holds the steps back. The
// step counter walking the control store sets the pace of the frames. Position
// registers are written through the cfg port, which never holds off a transfer,
// and should only be changed while no item is in progress.
module char_lcd_nibble_expander_writer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [clnw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  clnw_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output clnw_pkg::out_t                  out_data_o
);

  clnw_pkg::in_t        item;
  clnw_pkg::step_t      step;
  clnw_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  clnw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .status_i   (status),
    .item_o     (item),
    .step_o     (step)
  );

  clnw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .step_i      (step),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
